/* rtl/pps_pkg.sv */
// Shared constants, command and table types for the prime power sieve.
// No dependencies; every other file of the block imports this package.
package pps_pkg;

  // Largest value covered by the table; the table has MAX_VALUE + 1 entries
  localparam int MAX_VALUE = 65536;
  localparam int MEM_DEPTH = MAX_VALUE + 1;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  // Sweep counters hold a value one step past the limit
  localparam int IDX_W     = ADDR_W + 1;
  localparam int PROD_W    = 2 * ADDR_W;

  // Payload widths
  localparam int VAL_W = 17;
  localparam int DEG_W = 5;
  localparam int CNT_W = 13;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Action codes of an input item
  localparam logic ACT_BUILD = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Command queue between front and engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_SHIFT = 2;
  localparam logic [PADDR_W-REG_SHIFT-1:0] REG_UPPER_LIMIT = '0;
  localparam logic [VAL_W-1:0] UPPER_LIMIT_RESET = VAL_W'(MAX_VALUE);

  typedef enum logic [1:0] {
    CMD_BUILD,
    CMD_QUERY,
    CMD_MISS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  // One table entry; degree zero marks a value that is no prime power
  typedef struct packed {
    logic [VAL_W-1:0] chr;
    logic [DEG_W-1:0] deg;
  } pp_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_QRESP,
    S_CLEAR,
    S_SIEVE_CHK,
    S_SIEVE_TST,
    S_CROSS,
    S_MARK_RD,
    S_MARK_TST,
    S_POW_WR,
    S_POW_CHK,
    S_DONE
  } eng_state_t;

endpackage

/* rtl/pps_in_if.sv */
// Input channel of the prime power sieve: valid/ready with action and value.
// Depends on pps_pkg.
interface pps_in_if;
  import pps_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [VAL_W-1:0] query_value;

  modport source(output valid, action, query_value, input ready);
  modport sink(input valid, action, query_value, output ready);
endinterface

/* rtl/pps_out_if.sv */
// Result channel of the prime power sieve: valid/ready with the result fields.
// Depends on pps_pkg.
interface pps_out_if;
  import pps_pkg::*;

  logic             valid;
  logic             ready;
  logic             is_prime_power;
  logic [VAL_W-1:0] characteristic;
  logic [DEG_W-1:0] degree;
  logic [CNT_W-1:0] field_count;

  modport source(output valid, is_prime_power, characteristic, degree, field_count,
                 input ready);
  modport sink(input valid, is_prime_power, characteristic, degree, field_count,
               output ready);
endinterface

/* rtl/pps_front.sv */
// Front end: accepts input transfers, classifies them and queues commands.
// Depends on pps_pkg and pps_in_if.
module pps_front (
  input  logic          clk,
  input  logic          rst,
  pps_in_if.sink        in_ch,
  output logic          cmd_valid,
  output pps_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import pps_pkg::*;

  cmd_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  cmd_t              cmd_in;
  logic              push;
  logic              pop;

  // Classify: build, table lookup, or value beyond the table
  always_comb begin
    cmd_in.addr = ADDR_W'(in_ch.query_value);
    if (in_ch.action == ACT_BUILD) begin
      cmd_in.kind = CMD_BUILD;
    end else if (in_ch.query_value > VAL_W'(MAX_VALUE)) begin
      cmd_in.kind = CMD_MISS;
    end else begin
      cmd_in.kind = CMD_QUERY;
    end
  end

  assign in_ch.ready = (fill != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (fill != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_mem[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

/* rtl/pps_engine.sv */
// Back end: sieve, prime power table build and lookups, with result register.
// Depends on pps_pkg and pps_out_if; holds the composite bitmap and the table.
module pps_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cmd_valid,
  input  pps_pkg::cmd_t             cmd,
  output logic                      cmd_ready,
  input  logic [pps_pkg::VAL_W-1:0] upper_limit,
  pps_out_if.source                 out_ch
);
  import pps_pkg::*;

  eng_state_t state, state_next;

  // Limit of the running build, n / p sweep, n squared, m / v walker
  logic [IDX_W-1:0]  lim, lim_next;
  logic [IDX_W-1:0]  ptr, ptr_next;
  logic [IDX_W-1:0]  sq, sq_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [DEG_W-1:0]  deg, deg_next;
  logic [PROD_W-1:0] prod;
  logic [CNT_W-1:0]  count, count_next;
  logic              built, built_next;

  // Result register
  logic             res_valid, res_valid_next;
  logic             res_is_pp, res_is_pp_next;
  logic [VAL_W-1:0] res_chr, res_chr_next;
  logic [DEG_W-1:0] res_deg, res_deg_next;
  logic [CNT_W-1:0] res_cnt, res_cnt_next;
  logic             out_free;

  // Composite bitmap and prime power table
  logic              comp_mem [MEM_DEPTH];
  logic              comp_we;
  logic [ADDR_W-1:0] comp_waddr;
  logic              comp_wdata;
  logic [ADDR_W-1:0] comp_raddr;
  logic              comp_rdata;
  pp_entry_t         pp_mem [MEM_DEPTH];
  logic              pp_we;
  logic [ADDR_W-1:0] pp_waddr;
  pp_entry_t         pp_wdata;
  logic [ADDR_W-1:0] pp_raddr;
  pp_entry_t         pp_rdata;

  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[comp_waddr] <= comp_wdata;
    end
    comp_rdata <= comp_mem[comp_raddr];
  end

  always_ff @(posedge clk) begin
    if (pp_we) begin
      pp_mem[pp_waddr] <= pp_wdata;
    end
    pp_rdata <= pp_mem[pp_raddr];
  end

  assign out_free = !res_valid || out_ch.ready;

  // Next state, memory control and result load
  always_comb begin
    state_next     = state;
    lim_next       = lim;
    ptr_next       = ptr;
    sq_next        = sq;
    idx_next       = idx;
    deg_next       = deg;
    count_next     = count;
    built_next     = built;
    res_valid_next = res_valid && !out_ch.ready;
    res_is_pp_next = res_is_pp;
    res_chr_next   = res_chr;
    res_deg_next   = res_deg;
    res_cnt_next   = res_cnt;
    cmd_ready      = 1'b0;
    comp_we        = 1'b0;
    comp_waddr     = idx[ADDR_W-1:0];
    comp_wdata     = 1'b1;
    comp_raddr     = ptr[ADDR_W-1:0];
    pp_we          = 1'b0;
    pp_waddr       = idx[ADDR_W-1:0];
    pp_wdata.chr   = VAL_W'(ptr[ADDR_W-1:0]);
    pp_wdata.deg   = deg;
    pp_raddr       = cmd.addr;

    case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          case (cmd.kind)
            CMD_BUILD: begin
              lim_next   = (upper_limit > VAL_W'(MAX_VALUE)) ? IDX_W'(MAX_VALUE)
                                                             : IDX_W'(upper_limit);
              ptr_next   = '0;
              count_next = '0;
              state_next = S_CLEAR;
            end
            CMD_QUERY: begin
              if (built) begin
                state_next = S_QRESP;
              end else begin
                res_valid_next = 1'b1;
                res_is_pp_next = 1'b0;
                res_chr_next   = '0;
                res_deg_next   = '0;
                res_cnt_next   = count;
              end
            end
            default: begin
              res_valid_next = 1'b1;
              res_is_pp_next = 1'b0;
              res_chr_next   = '0;
              res_deg_next   = '0;
              res_cnt_next   = count;
            end
          endcase
        end
      end
      // Table entry lands; degree zero means no prime power
      S_QRESP: begin
        res_valid_next = 1'b1;
        res_is_pp_next = (pp_rdata.deg != '0);
        res_chr_next   = pp_rdata.chr;
        res_deg_next   = pp_rdata.deg;
        res_cnt_next   = count;
        state_next     = S_IDLE;
      end
      // Wipe both stores over the whole range
      S_CLEAR: begin
        comp_we    = 1'b1;
        comp_waddr = ptr[ADDR_W-1:0];
        comp_wdata = 1'b0;
        pp_we      = 1'b1;
        pp_waddr   = ptr[ADDR_W-1:0];
        pp_wdata   = '0;
        if (ptr == IDX_W'(MAX_VALUE)) begin
          if (lim < IDX_W'(2)) begin
            state_next = S_DONE;
          end else begin
            ptr_next   = IDX_W'(2);
            sq_next    = IDX_W'(4);
            state_next = S_SIEVE_CHK;
          end
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      // Sieve while n squared stays within the limit
      S_SIEVE_CHK: begin
        if (sq > lim) begin
          ptr_next   = IDX_W'(2);
          state_next = S_MARK_RD;
        end else begin
          state_next = S_SIEVE_TST;
        end
      end
      S_SIEVE_TST: begin
        if (!comp_rdata) begin
          idx_next   = sq;
          state_next = S_CROSS;
        end else begin
          ptr_next   = ptr + IDX_W'(1);
          sq_next    = sq + {ptr[IDX_W-2:0], 1'b0} + IDX_W'(1);
          state_next = S_SIEVE_CHK;
        end
      end
      // Cross out multiples of n from n squared up
      S_CROSS: begin
        if (idx > lim) begin
          ptr_next   = ptr + IDX_W'(1);
          sq_next    = sq + {ptr[IDX_W-2:0], 1'b0} + IDX_W'(1);
          state_next = S_SIEVE_CHK;
        end else begin
          comp_we  = 1'b1;
          idx_next = idx + ptr;
        end
      end
      // Walk p over 2..limit looking for primes
      S_MARK_RD: begin
        if (ptr > lim) begin
          state_next = S_DONE;
        end else begin
          state_next = S_MARK_TST;
        end
      end
      S_MARK_TST: begin
        if (!comp_rdata) begin
          idx_next   = ptr;
          deg_next   = DEG_W'(1);
          state_next = S_POW_WR;
        end else begin
          ptr_next   = ptr + IDX_W'(1);
          state_next = S_MARK_RD;
        end
      end
      // Record p^d; the product for the next power is registered meanwhile
      S_POW_WR: begin
        pp_we      = 1'b1;
        count_next = (count == COUNT_MAX) ? count : count + CNT_W'(1);
        state_next = S_POW_CHK;
      end
      S_POW_CHK: begin
        if (prod <= PROD_W'(lim)) begin
          idx_next   = IDX_W'(prod);
          deg_next   = deg + DEG_W'(1);
          state_next = S_POW_WR;
        end else begin
          ptr_next   = ptr + IDX_W'(1);
          state_next = S_MARK_RD;
        end
      end
      S_DONE: begin
        res_valid_next = 1'b1;
        res_is_pp_next = 1'b0;
        res_chr_next   = '0;
        res_deg_next   = '0;
        res_cnt_next   = count;
        built_next     = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      built     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      count     <= count_next;
      built     <= built_next;
      res_valid <= res_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lim       <= lim_next;
    ptr       <= ptr_next;
    sq        <= sq_next;
    idx       <= idx_next;
    deg       <= deg_next;
    prod      <= PROD_W'(idx[ADDR_W-1:0]) * PROD_W'(ptr[ADDR_W-1:0]);
    res_is_pp <= res_is_pp_next;
    res_chr   <= res_chr_next;
    res_deg   <= res_deg_next;
    res_cnt   <= res_cnt_next;
  end

  assign out_ch.valid          = res_valid;
  assign out_ch.is_prime_power = res_is_pp;
  assign out_ch.characteristic = res_chr;
  assign out_ch.degree         = res_deg;
  assign out_ch.field_count    = res_cnt;

  // A reported prime power carries a characteristic of at least two and a nonzero degree
  a_pp_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_is_pp |-> res_deg != '0 && res_chr >= VAL_W'(2))
    else $error("prime power result without prime or degree");

  // No count while idle before the first build has finished
  a_count_unbuilt: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && !built |-> count == '0)
    else $error("nonzero count before any build");

  // Table writes of powers never pass the limit
  a_pow_in_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_POW_WR |-> idx <= lim)
    else $error("power written beyond the limit");

  // The result slot is free when a lookup lands
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_QRESP |-> !res_valid)
    else $error("lookup result would overwrite a pending result");

  // Sieving only starts for a limit of at least two
  a_sieve_limit: assert property (@(posedge clk) disable iff (rst)
    state == S_SIEVE_CHK && $past(state) == S_CLEAR |-> lim >= IDX_W'(2))
    else $error("sieve started below the smallest prime");

endmodule

/* rtl/prime_power_sieve.sv */
// Prime power sieve top level: limit register, front queue and engine.
// Depends on pps_pkg, pps_in_if, pps_out_if, pps_front and pps_engine.
//
// Usage: items arrive on in_ch (valid/ready). action = 0 builds the table
// up to upper_limit (saturated to 65536); action = 1 looks up query_value.
// Every item yields one transfer on out_ch: lookups give is_prime_power,
// characteristic and degree; a build gives zeros there. field_count always
// carries the count of prime powers from the last build.
// Flow: a lookup passes the queue, then the table read (S_IDLE to S_QRESP) and
// the result register before it reaches out_ch; the engine takes the next
// command only once it is back in S_IDLE. A build wipes both stores over the
// whole range, sieves each n up to sqrt(limit) and crosses out its multiples,
// then walks every value up to the limit and records each prime power found.
// Items behind a build wait in the 2-entry queue.
// Reset: limit goes to 65536, queue and result empty; lookups report no
// prime power and a count of zero until the first build is done.
// Receiver stall: the result register holds; the queue keeps accepting
// until full, then in_ch.ready drops.
// upper_limit is written over APB at byte address 0; pready is always high.
module prime_power_sieve (
  input  logic                        clk,
  input  logic                        rst,
  pps_in_if.sink                      in_ch,
  pps_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pps_pkg::PADDR_W-1:0] paddr,
  input  logic [pps_pkg::PDATA_W-1:0] pwdata,
  output logic [pps_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import pps_pkg::*;

  logic [VAL_W-1:0] upper_limit;
  logic             reg_hit;
  logic             cmd_valid;
  cmd_t             cmd;
  logic             cmd_ready;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:REG_SHIFT] == REG_UPPER_LIMIT);

  // Write the limit register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UPPER_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      upper_limit <= pwdata[VAL_W-1:0];
    end
  end

  // Read back the limit
  always_comb begin
    prdata = reg_hit ? PDATA_W'(upper_limit) : '0;
  end

  pps_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  pps_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready),
    .upper_limit (upper_limit),
    .out_ch      (out_ch)
  );

endmodule

/* sim/pps_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the prime power sieve: watches both channels and the APB port.
// Keeps its own prime power table, predicts every result and compares it. Needs pps_pkg.
module pps_result_checker (
  input  logic                        clk,
  input  logic                        rst,
  pps_in_if                           in_mon,
  pps_out_if                          out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pps_pkg::PADDR_W-1:0] paddr,
  input  logic [pps_pkg::PDATA_W-1:0] pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          results_due
);
  import pps_pkg::*;

  typedef struct packed {
    logic             is_pp;
    logic [VAL_W-1:0] chr;
    logic [DEG_W-1:0] deg;
    logic [CNT_W-1:0] cnt;
  } pp_result_t;

  logic [VAL_W-1:0] limit_reg;
  bit               prime_flag [0:MAX_VALUE];
  bit               power_flag [0:MAX_VALUE];
  logic [VAL_W-1:0] char_tbl [0:MAX_VALUE];
  logic [DEG_W-1:0] deg_tbl [0:MAX_VALUE];
  logic [CNT_W-1:0] power_total;
  pp_result_t       pending_results[$];
  int               mismatch_total;

  // Wipe every table entry and the count
  function automatic void clear_power_table();
    for (int i = 0; i <= MAX_VALUE; i++) begin
      prime_flag[i] = 1'b0;
      power_flag[i] = 1'b0;
      char_tbl[i]   = '0;
      deg_tbl[i]    = '0;
    end
    power_total = '0;
  endfunction

  // Sieve the primes up to the saturated limit, then tag every p^d with p and d
  function automatic void rebuild_power_table(input logic [VAL_W-1:0] lim_in);
    int     lim;
    int     d;
    longint v;
    lim = (lim_in > MAX_VALUE) ? MAX_VALUE : int'(lim_in);
    clear_power_table();
    if (lim >= 2) begin
      for (int n = 2; n <= lim; n++) prime_flag[n] = 1'b1;
      for (int n = 2; n * n <= lim; n++) begin
        if (prime_flag[n]) begin
          for (int m = 2 * n; m <= lim; m += n) prime_flag[m] = 1'b0;
        end
      end
      for (int p = 2; p <= lim; p++) begin
        if (prime_flag[p]) begin
          v = p;
          d = 1;
          while (v <= lim) begin
            power_flag[v] = 1'b1;
            char_tbl[v]   = VAL_W'(p);
            deg_tbl[v]    = DEG_W'(d);
            if (power_total != COUNT_MAX) power_total++;
            v = v * p;
            d++;
          end
        end
      end
    end
  endfunction

  function automatic void report_field(input string name, input longint exp_v,
                                       input longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_total++;
    end
  endfunction

  always @(posedge clk) begin
    pp_result_t want;
    if (rst) begin
      limit_reg = UPPER_LIMIT_RESET;
      clear_power_table();
      pending_results.delete();
      mismatch_total = 0;
    end else begin
      // Predict the result of each accepted item, in input order
      if (in_mon.valid && in_mon.ready) begin
        want = '0;
        if (in_mon.action == ACT_BUILD) begin
          rebuild_power_table(limit_reg);
        end else if (in_mon.query_value <= MAX_VALUE && power_flag[in_mon.query_value]) begin
          want.is_pp = 1'b1;
          want.chr   = char_tbl[in_mon.query_value];
          want.deg   = deg_tbl[in_mon.query_value];
        end
        want.cnt = power_total;
        pending_results.push_back(want);
      end

      // Compare each result transfer with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no item outstanding");
          mismatch_total++;
        end else begin
          want = pending_results.pop_front();
          report_field("is_prime_power", want.is_pp, out_mon.is_prime_power);
          report_field("characteristic", want.chr, out_mon.characteristic);
          report_field("degree", want.deg, out_mon.degree);
          report_field("field_count", want.cnt, out_mon.field_count);
        end
      end

      // Track the limit register
      if (psel && penable && pwrite && pready &&
          paddr[PADDR_W-1:REG_SHIFT] == REG_UPPER_LIMIT) begin
        limit_reg = pwdata[VAL_W-1:0];
      end
    end
    fail_count  <= mismatch_total;
    results_due <= pending_results.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// Testbench top for the prime power sieve: clock, reset, APB writes and item stimulus.
// Needs pps_pkg, pps_in_if, pps_out_if, prime_power_sieve and pps_result_checker.
module tb;
  import pps_pkg::*;

  localparam int VAL_TOP         = (1 << VAL_W) - 1;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 4_000_000;

  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_MOSTLY_OPEN,
    RX_MOSTLY_SHUT
  } rx_mode_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 results_due;
  int                 hold_requests;
  int                 burst_left;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();

  prime_power_sieve dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  pps_result_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: stall on random segments, plus long hold-offs on request
  initial begin
    int       served;
    int       seg_len;
    int       hold_left;
    rx_mode_t mode;
    served    = 0;
    seg_len   = 0;
    hold_left = 0;
    mode      = RX_STEADY;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != served) begin
        served    = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_len == 0) begin
          seg_len = $urandom_range(16, 200);
          mode    = rx_mode_t'($urandom_range(0, 3));
        end
        seg_len--;
        case (mode)
          RX_STEADY:      out_ch.ready <= 1'b1;
          RX_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY_OPEN: out_ch.ready <= ($urandom_range(0, 4) != 0);
          default:        out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Write upper_limit over APB; entered and left at a falling edge
  task automatic write_limit(input logic [VAL_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(REG_UPPER_LIMIT) << REG_SHIFT;
    pwdata  <= PDATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item in bursts with random gaps; returns at the falling edge after the transfer
  task automatic send_item(input logic act, input logic [VAL_W-1:0] val);
    int gap_len;
    if (burst_left == 0) begin
      gap_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap_len) @(negedge clk);
      burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 8);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.query_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  // Drop valid and wait until every outstanding result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (results_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Mix of powers of small bases, plain values, values near the top and out of range
  function automatic logic [VAL_W-1:0] pick_query(input int lim);
    int     top_val;
    int     base;
    int     k;
    int     sel;
    longint v;
    top_val = (lim > MAX_VALUE) ? MAX_VALUE : ((lim < 2) ? 2 : lim);
    sel     = $urandom_range(0, 99);
    if (sel < 35) begin
      base = $urandom_range(2, 256);
      v    = base;
      k    = $urandom_range(1, 16);
      while (k > 1 && v * base <= top_val) begin
        v = v * base;
        k--;
      end
      return VAL_W'(v);
    end else if (sel < 60) begin
      return VAL_W'($urandom_range(0, top_val));
    end else if (sel < 70) begin
      return VAL_W'($urandom_range(0, 40));
    end else if (sel < 78) begin
      return VAL_W'(top_val - int'($urandom_range(0, 2)));
    end else if (sel < 84) begin
      return VAL_W'(MAX_VALUE - int'($urandom_range(0, 30)));
    end else if (sel < 93) begin
      return VAL_W'($urandom_range(MAX_VALUE + 1, VAL_TOP));
    end else begin
      return VAL_W'($urandom_range(0, VAL_TOP));
    end
  endfunction

  initial begin
    int lim;
    rst               = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_BUILD;
    in_ch.query_value = '0;
    hold_requests     = 0;
    burst_left        = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Queries before any build see an empty table
    send_item(ACT_QUERY, VAL_W'(0));
    send_item(ACT_QUERY, VAL_W'(MAX_VALUE));
    send_item(ACT_QUERY, VAL_W'(VAL_TOP));
    drain_results();

    // Smallest useful limit
    write_limit(VAL_W'(2));
    send_item(ACT_BUILD, VAL_W'(VAL_TOP));
    for (int i = 0; i <= 4; i++) send_item(ACT_QUERY, VAL_W'(i));
    drain_results();

    // Limits below two mark nothing
    write_limit(VAL_W'(0));
    send_item(ACT_BUILD, VAL_W'(0));
    send_item(ACT_QUERY, VAL_W'(2));
    drain_results();
    write_limit(VAL_W'(1));
    send_item(ACT_BUILD, VAL_W'(5));
    send_item(ACT_QUERY, VAL_W'(1));
    drain_results();

    // Small table, then move the limit without rebuilding
    write_limit(VAL_W'(97));
    send_item(ACT_BUILD, VAL_W'(0));
    send_item(ACT_QUERY, VAL_W'(64));
    send_item(ACT_QUERY, VAL_W'(81));
    send_item(ACT_QUERY, VAL_W'(96));
    send_item(ACT_QUERY, VAL_W'(97));
    drain_results();
    write_limit(VAL_W'(40000));
    send_item(ACT_QUERY, VAL_W'(97));
    send_item(ACT_QUERY, VAL_W'(101));
    drain_results();

    // Random small tables
    repeat (2) begin
      lim = $urandom_range(2, 3000);
      write_limit(VAL_W'(lim));
      send_item(ACT_BUILD, VAL_W'($urandom_range(0, VAL_TOP)));
      for (int i = 0; i < 200; i++) begin
        if (i == 30) hold_requests++;
        send_item(ACT_QUERY, pick_query(lim));
      end
      drain_results();
    end

    // Limit past the table size saturates to the full range
    write_limit(VAL_W'(VAL_TOP));
    send_item(ACT_BUILD, VAL_W'($urandom_range(0, VAL_TOP)));
    send_item(ACT_QUERY, VAL_W'(MAX_VALUE));
    send_item(ACT_QUERY, VAL_W'(65521));
    send_item(ACT_QUERY, VAL_W'(59049));
    send_item(ACT_QUERY, VAL_W'(65535));
    send_item(ACT_QUERY, VAL_W'(MAX_VALUE + 1));
    for (int i = 0; i < 1100; i++) begin
      if (i == 400) hold_requests++;
      send_item(ACT_QUERY, pick_query(MAX_VALUE));
    end
    drain_results();
    repeat (20) @(negedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
